>>> rtl/rms_voltage_window_meter_assert.svh
// ----------------------------------------------------------------------------
// rms_voltage_window_meter assertion macros
// Concurrent assertion wrappers; ASSERT_OFF compiles them away.
// ----------------------------------------------------------------------------
`ifndef RMS_VOLTAGE_WINDOW_METER_ASSERT_SVH
`define RMS_VOLTAGE_WINDOW_METER_ASSERT_SVH

`ifndef ASSERT_OFF
`define RVWM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rvwm assertion failed");
`define RVWM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rvwm assertion failed");
`else
`define RVWM_ASSERT(lbl, clk, rst_n, prop)
`define RVWM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/rvwm_pkg.sv
// ----------------------------------------------------------------------------
// rvwm_pkg
// Shared types, constants and the control store of the RMS window meter.
// ----------------------------------------------------------------------------
`default_nettype none

package rvwm_pkg;

    localparam int SUM_W      = 36;
    localparam int CNT_W      = 16;
    localparam int VCC_W      = 24;
    localparam int RMS_W      = 23;
    localparam int DIVR_W     = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;
    localparam int DIV_STEPS  = SUM_W;
    localparam int MUL_STEPS  = VCC_W;

    localparam logic [RMS_W-1:0]     RMS_MAX          = 23'h7FFFFF;
    localparam logic [CNT_W-1:0]     SAMPLE_COUNT_RST = 16'd64;
    localparam logic [VCC_W-1:0]     VREF_CONST_RST   = 24'd1125300;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_VREF_CONST   = 1'b1;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCUM,
        OP_DIVM_INIT,
        OP_DIVV_INIT,
        OP_DIV_STEP,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_MUL_INIT,
        OP_MUL_STEP,
        OP_FINISH
    } t_op;

    typedef enum logic [1:0] {
        C_NEXT,
        C_LOOP,
        C_GO_CLOSE,
        C_GO_OUT
    } t_cond;

    typedef enum logic [1:0] {
        LD_NONE,
        LD_DIV,
        LD_SQRT,
        LD_MUL
    } t_cnt_ld;

    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] t_step;

    localparam t_step S_ACCUM     = 4'd0;
    localparam t_step S_DIVM_INIT = 4'd1;
    localparam t_step S_DIV_M     = 4'd2;
    localparam t_step S_SQRT_INIT = 4'd3;
    localparam t_step S_SQRT      = 4'd4;
    localparam t_step S_DIVV_INIT = 4'd5;
    localparam t_step S_DIV_V     = 4'd6;
    localparam t_step S_MUL_INIT  = 4'd7;
    localparam t_step S_MUL       = 4'd8;
    localparam t_step S_FINISH    = 4'd9;

    typedef struct packed {
        t_op     op;
        t_cond   cond;
        t_cnt_ld cnt_ld;
        t_step   target;
    } t_uword;

    typedef struct packed {
        logic close_go;
        logic out_free;
    } t_dp_stat;

    function automatic t_uword f_ucode(input t_step step);
        t_uword uw;
        unique case (step)
            S_ACCUM:     uw = '{OP_ACCUM,     C_GO_CLOSE, LD_NONE, S_ACCUM};
            S_DIVM_INIT: uw = '{OP_DIVM_INIT, C_NEXT,     LD_DIV,  S_ACCUM};
            S_DIV_M:     uw = '{OP_DIV_STEP,  C_LOOP,     LD_NONE, S_DIV_M};
            S_SQRT_INIT: uw = '{OP_SQRT_INIT, C_NEXT,     LD_SQRT, S_ACCUM};
            S_SQRT:      uw = '{OP_SQRT_STEP, C_LOOP,     LD_NONE, S_SQRT};
            S_DIVV_INIT: uw = '{OP_DIVV_INIT, C_NEXT,     LD_DIV,  S_ACCUM};
            S_DIV_V:     uw = '{OP_DIV_STEP,  C_LOOP,     LD_NONE, S_DIV_V};
            S_MUL_INIT:  uw = '{OP_MUL_INIT,  C_NEXT,     LD_MUL,  S_ACCUM};
            S_MUL:       uw = '{OP_MUL_STEP,  C_LOOP,     LD_NONE, S_MUL};
            S_FINISH:    uw = '{OP_FINISH,    C_GO_OUT,   LD_NONE, S_ACCUM};
            default:     uw = '{OP_NOP,       C_NEXT,     LD_NONE, S_ACCUM};
        endcase
        return uw;
    endfunction

endpackage

`default_nettype wire

>>> rtl/rvwm_seq.sv
// ----------------------------------------------------------------------------
// rvwm_seq
// Step counter, loop counter and control store lookup.
// ----------------------------------------------------------------------------
`default_nettype none

module rvwm_seq #(
    parameter int SQRT_STEPS = 26
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire rvwm_pkg::t_dp_stat i_stat,
    output rvwm_pkg::t_op           o_op
);
    import rvwm_pkg::*;

    localparam int MAX_A     = (DIV_STEPS > MUL_STEPS) ? DIV_STEPS : MUL_STEPS;
    localparam int MAX_STEPS = (MAX_A > SQRT_STEPS) ? MAX_A : SQRT_STEPS;
    localparam int LCNT_W    = (MAX_STEPS > 2) ? $clog2(MAX_STEPS) : 1;

    t_step             r_step, n_step;
    logic [LCNT_W-1:0] r_cnt, n_cnt;
    t_uword            uw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_ACCUM;
            r_cnt  <= '0;
        end else begin
            r_step <= n_step;
            r_cnt  <= n_cnt;
        end
    end

    always_comb begin
        uw     = f_ucode(r_step);
        n_step = r_step;
        n_cnt  = r_cnt;
        case (uw.cnt_ld)
            LD_DIV:  n_cnt = LCNT_W'(DIV_STEPS - 1);
            LD_SQRT: n_cnt = LCNT_W'(SQRT_STEPS - 1);
            LD_MUL:  n_cnt = LCNT_W'(MUL_STEPS - 1);
            default: n_cnt = r_cnt;
        endcase
        unique case (uw.cond)
            C_NEXT: n_step = r_step + 1'b1;
            C_LOOP: begin
                if (r_cnt != '0) begin
                    n_step = uw.target;
                    n_cnt  = r_cnt - 1'b1;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            C_GO_CLOSE: begin
                if (i_stat.close_go) begin
                    n_step = r_step + 1'b1;
                end
            end
            C_GO_OUT: begin
                if (i_stat.out_free) begin
                    n_step = uw.target;
                end
            end
            default: n_step = S_ACCUM;
        endcase
    end

    assign o_op = uw.op;

endmodule

`default_nettype wire

>>> rtl/rvwm_dp.sv
// ----------------------------------------------------------------------------
// rvwm_dp
// Accumulator, shared divider, root extractor, shift-add multiplier, output.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rms_voltage_window_meter_assert.svh"

module rvwm_dp #(
    parameter int ADC_BITS       = 10,
    parameter int ROOT_FRAC_BITS = 8
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire rvwm_pkg::t_op                       i_op,
    output rvwm_pkg::t_dp_stat                       o_stat,
    input  wire logic                                i_cfg_we,
    input  wire logic [rvwm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [rvwm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [ADC_BITS-1:0]                 i_sample,
    input  wire logic [ADC_BITS-1:0]                 i_ref_code,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic [rvwm_pkg::RMS_W-1:0]               o_rms_mv,
    output logic [rvwm_pkg::VCC_W-1:0]               o_vcc_mv,
    output logic                                     o_status
);
    import rvwm_pkg::*;

    localparam int SQ_W = 2 * ADC_BITS;
    localparam int RW   = SUM_W / 2 + ROOT_FRAC_BITS;
    localparam int XW   = SUM_W + 2 * ROOT_FRAC_BITS;
    localparam int PW   = RW + VCC_W;
    localparam int SHR  = ADC_BITS + ROOT_FRAC_BITS;
    localparam logic [ADC_BITS-1:0] MID = ADC_BITS'(1) << (ADC_BITS - 1);

    logic [CNT_W-1:0]  r_sample_count;
    logic [VCC_W-1:0]  r_vref;
    logic [SUM_W-1:0]  r_sum;
    logic [CNT_W-1:0]  r_index;
    logic              r_out_valid;
    logic [ADC_BITS-1:0] r_ref;
    logic [SUM_W-1:0]  r_quo;
    logic [DIVR_W-1:0] r_rem;
    logic [DIVR_W-1:0] r_divisor;
    logic [XW-1:0]     r_rad;
    logic [RW:0]       r_srem;
    logic [RW-1:0]     r_root;
    logic [PW-1:0]     r_acc;
    logic [VCC_W-1:0]  r_mplier;
    logic [RMS_W-1:0]  r_rms;
    logic [VCC_W-1:0]  r_vcc;
    logic              r_status;

    logic [ADC_BITS-1:0] mag;
    logic [SQ_W-1:0]     sq;
    logic [SUM_W-1:0]    sum_next;
    logic [CNT_W-1:0]    count_eff;
    logic                close;
    logic                accept;
    logic                out_free;
    logic                fin;
    logic [DIVR_W:0]     d_cur;
    logic                d_ge;
    logic [DIVR_W:0]     d_new;
    logic [RW+2:0]       s_cur;
    logic [RW+2:0]       s_try;
    logic                s_ge;
    logic [PW-1:0]       prod_shr;
    logic [RMS_W-1:0]    rms_sat;

    always_comb begin
        mag       = (i_sample >= MID) ? (i_sample - MID) : (MID - i_sample);
        sq        = SQ_W'(mag) * SQ_W'(mag);
        sum_next  = r_sum + SUM_W'(sq);
        count_eff = (r_sample_count == '0) ? CNT_W'(1) : r_sample_count;
        close     = ((CNT_W + 1)'(r_index) + 1'b1) >= (CNT_W + 1)'(count_eff);
        accept    = i_in_valid && (i_op == OP_ACCUM);
        out_free  = !r_out_valid || !i_out_stall;
        fin       = (i_op == OP_FINISH) && out_free;

        d_cur = {r_rem, r_quo[SUM_W-1]};
        d_ge  = d_cur >= {1'b0, r_divisor};
        d_new = d_ge ? (d_cur - {1'b0, r_divisor}) : d_cur;

        s_cur = {r_srem, r_rad[XW-1 -: 2]};
        s_try = {1'b0, r_root, 2'b01};
        s_ge  = s_cur >= s_try;

        prod_shr = r_acc >> SHR;
        rms_sat  = (prod_shr > PW'(RMS_MAX)) ? RMS_MAX : prod_shr[RMS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count <= SAMPLE_COUNT_RST;
            r_vref         <= VREF_CONST_RST;
            r_sum          <= '0;
            r_index        <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_SAMPLE_COUNT: r_sample_count <= i_cfg_data[CNT_W-1:0];
                    REG_VREF_CONST:   r_vref         <= i_cfg_data[VCC_W-1:0];
                    default:          r_vref         <= r_vref;
                endcase
            end
            if (accept) begin
                r_sum   <= sum_next;
                r_index <= close ? '0 : r_index + 1'b1;
            end else if (i_op == OP_DIVM_INIT) begin
                r_sum <= '0;
            end
            if (out_free) begin
                r_out_valid <= fin;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && close) begin
            r_ref <= i_ref_code;
        end
        case (i_op)
            OP_DIVM_INIT: begin
                r_quo     <= r_sum;
                r_rem     <= '0;
                r_divisor <= count_eff;
            end
            OP_DIVV_INIT: begin
                r_quo     <= SUM_W'(r_vref);
                r_rem     <= '0;
                r_divisor <= DIVR_W'(r_ref);
            end
            OP_DIV_STEP: begin
                r_quo <= {r_quo[SUM_W-2:0], d_ge};
                r_rem <= d_new[DIVR_W-1:0];
            end
            OP_SQRT_INIT: begin
                r_rad  <= XW'(r_quo) << (2 * ROOT_FRAC_BITS);
                r_srem <= '0;
                r_root <= '0;
            end
            OP_SQRT_STEP: begin
                r_rad  <= r_rad << 2;
                r_srem <= s_ge ? (RW + 1)'(s_cur - s_try) : s_cur[RW:0];
                r_root <= {r_root[RW-2:0], s_ge};
            end
            OP_MUL_INIT: begin
                r_acc    <= '0;
                r_mplier <= r_quo[VCC_W-1:0];
            end
            OP_MUL_STEP: begin
                r_acc    <= (r_acc << 1) + (r_mplier[VCC_W-1] ? PW'(r_root) : '0);
                r_mplier <= r_mplier << 1;
            end
            default: r_acc <= r_acc;
        endcase
        if (fin) begin
            if (r_ref == '0) begin
                r_rms    <= '0;
                r_vcc    <= '0;
                r_status <= 1'b1;
            end else begin
                r_rms    <= rms_sat;
                r_vcc    <= r_quo[VCC_W-1:0];
                r_status <= 1'b0;
            end
        end
    end

    assign o_stat.close_go = accept && close;
    assign o_stat.out_free = out_free;
    assign o_in_stall      = (i_op != OP_ACCUM);
    assign o_out_valid     = r_out_valid;
    assign o_rms_mv        = r_rms;
    assign o_vcc_mv        = r_vcc;
    assign o_status        = r_status;

    `RVWM_ASSERT(a_status_zero, i_clk, i_rst_n, (r_out_valid && r_status) |-> (r_rms == '0 && r_vcc == '0))
    `RVWM_ASSERT(a_out_from_finish, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(i_op == OP_FINISH))
    `RVWM_ASSERT_NEXT(a_window_clear, i_clk, i_rst_n, i_op == OP_DIVM_INIT, r_sum == '0 && r_index == '0)

endmodule

`default_nettype wire

>>> rtl/rms_voltage_window_meter.sv
// ----------------------------------------------------------------------------
// rms_voltage_window_meter
// True RMS meter over a window of ADC samples, scaled by the supply voltage.
// Input channel: i_in_valid / o_in_stall carry one request of i_sample and
// i_ref_code. A request that does not close the window is taken without a stall.
// The request that closes the window starts the divide, root and scale
// program; its result leaves on o_out_valid / i_out_stall after the
// 36-step shared divider used twice, the root unit and the 24-step
// shift-add multiplier have run.
// o_in_stall stays high while the program runs.
// Results wait in an output register; if the receiver stalls, the program
// holds in its last step until the register frees.
// Reset restores sample_count 64 and vref_const 1125300 and empties the window.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
// (0 sample_count, 1 vref_const); the user writes only while block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module rms_voltage_window_meter #(
    parameter int ADC_BITS       = 10,
    parameter int ROOT_FRAC_BITS = 8
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [rvwm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [rvwm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [ADC_BITS-1:0]             i_sample,
    input  wire logic [ADC_BITS-1:0]             i_ref_code,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [rvwm_pkg::RMS_W-1:0]           o_rms_mv,
    output logic [rvwm_pkg::VCC_W-1:0]           o_vcc_mv,
    output logic                                 o_status
);
    import rvwm_pkg::*;

    localparam int SQRT_STEPS = SUM_W / 2 + ROOT_FRAC_BITS;

    t_op      op;
    t_dp_stat stat;

    rvwm_seq #(
        .SQRT_STEPS(SQRT_STEPS)
    ) u_seq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_stat (stat),
        .o_op   (op)
    );

    rvwm_dp #(
        .ADC_BITS      (ADC_BITS),
        .ROOT_FRAC_BITS(ROOT_FRAC_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (op),
        .o_stat     (stat),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sample   (i_sample),
        .i_ref_code (i_ref_code),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_rms_mv   (o_rms_mv),
        .o_vcc_mv   (o_vcc_mv),
        .o_status   (o_status)
    );

endmodule

`default_nettype wire
